// ===== rtl/text_console_cursor_escape_control_defines.svh =====
// ----------------------------------------------------------------------------
// Text console assertion macros
// Shared assertion macros for the console cursor and escape control logic.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ESCAPE_CONTROL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ESCAPE_CONTROL_DEFINES_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define TCON_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define TCON_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCON_ASSERT(lbl, prop, msg)
`define TCON_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/tcon_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console package
// Command codes, parser states, character codes and the result beat type.
// ----------------------------------------------------------------------------
package tcon_pkg;

	typedef enum logic [1:0] {
		CMD_DRAW   = 2'd0,
		CMD_SCROLL = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		PS_NORMAL  = 2'd0,
		PS_ESCAPE  = 2'd1,
		PS_COMMAND = 2'd2,
		PS_UNUSED  = 2'd3
	} parse_t;

	localparam logic [7:0] CH_ESC       = 8'd27;
	localparam logic [7:0] CH_BRACKET   = 8'h5B;
	localparam logic [7:0] CH_K         = 8'h4B;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_PRINTABLE = 8'd32;
	localparam int         CELL_HEIGHT  = 16;
	localparam int         CELL_WIDTH   = 8;
	localparam logic [6:0] ROW_MAX      = 7'd127;

	typedef struct packed {
		cmd_t        command;
		logic [7:0]  glyph;
		logic [6:0]  cursor_column;
		logic [6:0]  cursor_row;
		logic [20:0] pixel_offset;
		logic        last;
	} result_t;

endpackage

// ===== rtl/text_console_cursor_escape_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor and escape control
// Turns console bytes into draw, scroll and clear-to-end-of-line commands.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+---------------------------------------
//   input   | in_valid / in_stall  | char_code
//   output  | out_valid / out_stall| command, glyph, cursor_column,
//           |                      | cursor_row, pixel_offset, last
//
// A byte is decoded in the cycle it is accepted and its zero, one or two
// result beats are written to a four-entry result queue; a new byte can be
// taken every cycle while the queue has room. A byte that causes two beats
// puts them on the output one after the other. The input stalls while
// fewer than two entries are free. Reset clears cursor, parser and queue.
// ----------------------------------------------------------------------------
`include "text_console_cursor_escape_control_defines.svh"

module text_console_cursor_escape_control #(
	parameter int COLUMNS    = 128,
	parameter int ROWS       = 64,
	parameter int LINE_PITCH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        char_code,
	output logic              out_valid,
	input  logic              out_stall,
	output tcon_pkg::cmd_t    command,
	output logic [7:0]        glyph,
	output logic [6:0]        cursor_column,
	output logic [6:0]        cursor_row,
	output logic [20:0]       pixel_offset,
	output logic              last
);
	import tcon_pkg::*;

	localparam logic [7:0] COLUMNS_W  = 8'(COLUMNS);
	localparam logic [6:0] ROWS_W     = 7'(ROWS);
	localparam logic [6:0] BOTTOM_ROW = 7'(ROWS - 1);
	localparam logic [31:0] ROW_STEP  = 32'(CELL_HEIGHT * LINE_PITCH);

	logic [7:0]  column_q;
	logic [6:0]  row_q;
	parse_t      ps_q;

	result_t     queue_q [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  count_q;

	logic        in_fire;
	logic        pop;
	logic [1:0]  n_res;
	result_t     res0;
	result_t     res1;
	logic [7:0]  column_d;
	logic [6:0]  row_d;
	parse_t      ps_d;
	logic        scroll;
	logic        draw;
	logic        clear;
	logic [6:0]  draw_row;
	logic [6:0]  lf_row;
	logic [7:0]  col_inc;
	logic [7:0]  cell_col;
	logic [6:0]  cell_row;
	logic [31:0] offset_full;
	result_t     cell_res;
	result_t     scroll_res;
	result_t     head;

	assign in_stall = count_q > 3'd2;
	assign in_fire  = in_valid && !in_stall;
	assign out_valid = count_q != 3'd0;
	assign pop      = out_valid && !out_stall;

	always_comb begin
		column_d = column_q;
		row_d    = row_q;
		ps_d     = ps_q;
		scroll   = 1'b0;
		draw     = 1'b0;
		clear    = 1'b0;
		draw_row = (row_q >= ROWS_W) ? BOTTOM_ROW : row_q;
		lf_row   = (row_q < ROW_MAX) ? row_q + 7'd1 : row_q;
		col_inc  = column_q + 8'd1;
		unique case (ps_q)
			PS_NORMAL: begin
				if (char_code >= CH_PRINTABLE) begin
					scroll = row_q >= ROWS_W;
					draw   = 1'b1;
					row_d  = draw_row;
					column_d = col_inc;
					if (col_inc >= COLUMNS_W) begin
						column_d = 8'd0;
						if (draw_row < ROW_MAX) begin
							row_d = draw_row + 7'd1;
						end
					end
				end else if (char_code == CH_CR) begin
					column_d = 8'd0;
				end else if (char_code == CH_LF) begin
					column_d = 8'd0;
					row_d    = lf_row;
					if (lf_row >= ROWS_W) begin
						scroll = 1'b1;
						row_d  = BOTTOM_ROW;
					end
				end else if (char_code == CH_ESC) begin
					ps_d = PS_ESCAPE;
				end
			end
			PS_ESCAPE: begin
				if (char_code == CH_BRACKET) begin
					ps_d = PS_COMMAND;
				end else begin
					clear = (char_code == CH_K) && (row_q < ROWS_W);
					ps_d  = PS_NORMAL;
				end
			end
			PS_COMMAND: begin
				clear = (char_code == CH_K) && (row_q < ROWS_W);
				ps_d  = PS_NORMAL;
			end
			default: begin
				ps_d = PS_NORMAL;
			end
		endcase
	end

	always_comb begin
		cell_col    = column_q;
		cell_row    = draw ? draw_row : row_q;
		offset_full = ({24'd0, cell_col} * 32'(CELL_WIDTH)) + ({25'd0, cell_row} * ROW_STEP);

		cell_res.command       = draw ? CMD_DRAW : CMD_CLEAR;
		cell_res.glyph         = draw ? char_code : 8'd0;
		cell_res.cursor_column = cell_col[6:0];
		cell_res.cursor_row    = cell_row;
		cell_res.pixel_offset  = offset_full[20:0];
		cell_res.last          = 1'b1;

		scroll_res.command       = CMD_SCROLL;
		scroll_res.glyph         = 8'd0;
		scroll_res.cursor_column = 7'd0;
		scroll_res.cursor_row    = 7'd0;
		scroll_res.pixel_offset  = 21'd0;
		scroll_res.last          = !draw;

		res0  = scroll ? scroll_res : cell_res;
		res1  = cell_res;
		n_res = 2'({1'b0, scroll}) + 2'({1'b0, draw || clear});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= 8'd0;
			row_q    <= 7'd0;
			ps_q     <= PS_NORMAL;
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (in_fire) begin
				column_q <= column_d;
				row_q    <= row_d;
				ps_q     <= ps_d;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			if (in_fire) begin
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			count_q <= count_q + (in_fire ? {1'b0, n_res} : 3'd0) - {2'd0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && n_res != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (in_fire && n_res == 2'd2) begin
			queue_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	assign head          = queue_q[rd_ptr_q];
	assign command       = head.command;
	assign glyph         = head.glyph;
	assign cursor_column = head.cursor_column;
	assign cursor_row    = head.cursor_row;
	assign pixel_offset  = head.pixel_offset;
	assign last          = head.last;

	`TCON_ASSERT_ALWAYS(a_count_bound, count_q <= 3'd4, "Result queue count exceeds its depth.")
	`TCON_ASSERT(a_row_bound, row_q <= ROWS_W, "Cursor row is past the pending-scroll row.")
	`TCON_ASSERT(a_col_bound, column_q < COLUMNS_W, "Cursor column is outside the screen.")
	`TCON_ASSERT(a_two_beats, (in_fire && n_res == 2'd2 && !pop) |=> count_q == $past(count_q) + 3'd2, "A two-beat byte did not add two queue entries.")

endmodule
